FILE: hdl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// RGB median filter package
// Payload types, cell link type, sequencer states and register map.
// ----------------------------------------------------------------------------
package rmf_pkg;

   // input transfer payload
   typedef struct packed {
      logic       command;
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_payload_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       frame_last;
   } rsp_payload_type;

   // one pixel, blue in the low byte
   localparam int PIX_W   = 24;
   localparam int LANES   = 3;
   localparam int SAMPLE_W = 8;

   // item command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // register map
   localparam int          ADDR_W       = 4;
   localparam logic [1:0]  REG_WIDTH    = 2'd0;
   localparam logic [1:0]  REG_HEIGHT   = 2'd1;
   localparam logic [1:0]  REG_WINDOW   = 2'd2;
   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [10:0] HEIGHT_RESET = 11'd480;
   localparam logic [2:0]  WINDOW_RESET = 3'd3;

   // link handed from one sort cell to the next
   typedef struct packed {
      logic [LANES-1:0] lt;
      logic [LANES-1:0] valid;
      logic [PIX_W-1:0] value;
   } cell_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_SETTLE,
      ST_DONE
   } seq_state_type;

endpackage

FILE: hdl/rgb_median_filter.sv
// Sequence: an item with no result is taken while idle; one with a result runs
//   gather (N*N window reads, one line store read a cycle), settle and done.
// Throughput: one item at a time, set by the single read port of the line
//   store feeding the insertion chain.
// Reset: synchronous, active high; clears counters, sequencer and result
//   valid; registers return to 640 x 480, window 3.
// ----------------------------------------------------------------------------
// RGB median filter
// Streaming per-channel median over an odd window with mirrored borders.
// ----------------------------------------------------------------------------
module rgb_median_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_WINDOW = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rmf_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rmf_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rmf_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int HALF = (MAX_WINDOW - 1) / 2;
   localparam int RING = 2 * HALF + 2;
   localparam int RB   = $clog2(RING);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int MW   = $clog2(HALF + 1);
   localparam int SW   = $clog2(2 * HALF + 1);
   localparam int NC   = (2 * HALF + 1) * (2 * HALF + 1);
   localparam int IW   = $clog2(NC);
   localparam int AW   = RB + CW;
   localparam int LAGW = $clog2(HALF * MAX_WIDTH + HALF + 2);
   localparam int YW   = HW + 2;
   localparam int XW   = WW + 2;
   localparam logic signed [YW-1:0] Y_ONE = YW'(1);
   localparam logic signed [XW-1:0] X_ONE = XW'(1);

   // configuration registers
   logic [10:0] cfg_w_ff, cfg_h_ff;
   logic [2:0]  cfg_n_ff;
   logic        cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= rmf_pkg::WIDTH_RESET;
         cfg_h_ff <= rmf_pkg::HEIGHT_RESET;
         cfg_n_ff <= rmf_pkg::WINDOW_RESET;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            rmf_pkg::REG_WIDTH:  cfg_w_ff <= csr_pwdata[10:0];
            rmf_pkg::REG_HEIGHT: cfg_h_ff <= csr_pwdata[10:0];
            rmf_pkg::REG_WINDOW: cfg_n_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_paddr[3:2])
         rmf_pkg::REG_WIDTH:  csr_prdata = {21'd0, cfg_w_ff};
         rmf_pkg::REG_HEIGHT: csr_prdata = {21'd0, cfg_h_ff};
         rmf_pkg::REG_WINDOW: csr_prdata = {29'd0, cfg_n_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // effective frame geometry from the registers
   logic [12:0]   w13, h13;
   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [2:0]    n_nz, n_odd;
   logic [3:0]    m4;
   logic [MW-1:0] eff_m;

   always_comb begin
      w13 = 13'(cfg_w_ff);
      h13 = 13'(cfg_h_ff);
      if (w13 == 13'd0)                  eff_w = WW'(1);
      else if (w13 > 13'(MAX_WIDTH))     eff_w = WW'(MAX_WIDTH);
      else                               eff_w = WW'(w13);
      if (h13 == 13'd0)                  eff_h = HW'(1);
      else if (h13 > 13'(MAX_HEIGHT))    eff_h = HW'(MAX_HEIGHT);
      else                               eff_h = HW'(h13);
      n_nz  = (cfg_n_ff == 3'd0) ? 3'd1 : cfg_n_ff;
      n_odd = n_nz[0] ? n_nz : n_nz - 3'd1;
      m4    = 4'(n_odd >> 1);
      if (m4 > 4'(HALF)) m4 = 4'(HALF);
      if (13'(m4) > 13'(eff_w) - 13'd1) m4 = 4'(13'(eff_w) - 13'd1);
      if (13'(m4) > 13'(eff_h) - 13'd1) m4 = 4'(13'(eff_h) - 13'd1);
      eff_m = MW'(m4);
   end

   // frame state
   rmf_pkg::seq_state_type state_ff, state_in;
   logic [WW-1:0]   lat_w_ff, lat_w_in;
   logic [HW-1:0]   lat_h_ff, lat_h_in;
   logic [MW-1:0]   lat_m_ff, lat_m_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [HW-1:0]   row_ff, row_in;
   logic [CW-1:0]   ex_ff, ex_in;
   logic [HW-1:0]   ey_ff, ey_in;
   logic [LAGW-1:0] diff_ff, diff_in;
   logic [CW-1:0]   gx_ff, gx_in;
   logic [HW-1:0]   gy_ff, gy_in;
   logic            last_ff, last_in;
   logic [IW-1:0]   mid_ff, mid_in;
   logic [SW-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic            rd_pend_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rmf_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept, latch_now, produce, wr_en;
   logic [WW-1:0]   cur_w;
   logic [HW-1:0]   cur_h;
   logic [MW-1:0]   cur_m;
   logic [LAGW-1:0] lag, diff_inc;
   logic [SW-1:0]   span;
   logic            gather_end, issue, load_rsp, rsp_free;

   assign accept    = req_valid && !req_stall;
   assign latch_now = (req_data.command == rmf_pkg::CMD_PIXEL) &&
                      row_ff == '0 && col_ff == '0 && ey_ff == '0 && ex_ff == '0;
   assign cur_w     = latch_now ? eff_w : lat_w_ff;
   assign cur_h     = latch_now ? eff_h : lat_h_ff;
   assign cur_m     = latch_now ? eff_m : lat_m_ff;
   assign lag       = LAGW'(cur_m) * LAGW'(cur_w) + LAGW'(cur_m);
   assign diff_inc  = diff_ff + LAGW'(1);
   assign span      = SW'({lat_m_ff, 1'b0});
   assign gather_end = (dx_ff == span) && (dy_ff == span);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // decide what an accepted item does
   always_comb begin
      produce = 1'b0;
      wr_en   = 1'b0;
      if (accept) begin
         if (req_data.command == rmf_pkg::CMD_PIXEL) begin
            if (row_ff != cur_h) begin
               wr_en   = 1'b1;
               produce = diff_inc > lag;
            end
         end else begin
            produce = (row_ff == lat_h_ff);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmf_pkg::ST_IDLE:   if (produce) state_in = rmf_pkg::ST_GATHER;
         rmf_pkg::ST_GATHER: if (gather_end) state_in = rmf_pkg::ST_SETTLE;
         rmf_pkg::ST_SETTLE: state_in = rmf_pkg::ST_DONE;
         rmf_pkg::ST_DONE:   if (rsp_free) state_in = rmf_pkg::ST_IDLE;
         default:            state_in = rmf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         rmf_pkg::ST_IDLE:   req_stall = 1'b0;
         rmf_pkg::ST_GATHER: issue = 1'b1;
         rmf_pkg::ST_SETTLE: ;
         rmf_pkg::ST_DONE:   load_rsp = rsp_free;
         default:            ;
      endcase
   end

   // advance counters
   always_comb begin
      lat_w_in = lat_w_ff;
      lat_h_in = lat_h_ff;
      lat_m_in = lat_m_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      diff_in  = diff_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      last_in  = last_ff;
      mid_in   = mid_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      if (accept && latch_now) begin
         lat_w_in = eff_w;
         lat_h_in = eff_h;
         lat_m_in = eff_m;
      end
      if (wr_en) begin
         if (WW'(col_ff) == cur_w - WW'(1)) begin
            col_in = '0;
            row_in = row_ff + HW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (!produce) diff_in = diff_inc;
      end
      if (produce) begin
         gx_in   = ex_ff;
         gy_in   = ey_ff;
         dx_in   = '0;
         dy_in   = '0;
         mid_in  = IW'(2 * int'(cur_m) * (int'(cur_m) + 1));
         last_in = (ey_ff == cur_h - HW'(1)) && (WW'(ex_ff) == cur_w - WW'(1));
         if (WW'(ex_ff) == cur_w - WW'(1)) begin
            ex_in = '0;
            ey_in = ey_ff + HW'(1);
         end else begin
            ex_in = ex_ff + CW'(1);
         end
         if (last_in) begin
            col_in  = '0;
            row_in  = '0;
            ex_in   = '0;
            ey_in   = '0;
            diff_in = '0;
         end
      end
      if (issue) begin
         if (dx_ff == span) begin
            dx_in = '0;
            dy_in = dy_ff + SW'(1);
         end else begin
            dx_in = dx_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rmf_pkg::ST_IDLE;
         lat_w_ff   <= WW'(1);
         lat_h_ff   <= HW'(1);
         lat_m_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         ex_ff      <= '0;
         ey_ff      <= '0;
         diff_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         lat_w_ff   <= lat_w_in;
         lat_h_ff   <= lat_h_in;
         lat_m_ff   <= lat_m_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         ex_ff      <= ex_in;
         ey_ff      <= ey_in;
         diff_ff    <= diff_in;
         rd_pend_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      last_ff <= last_in;
      mid_ff  <= mid_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

   // mirrored window coordinates
   logic signed [YW-1:0] ty_s, ty_m, hh;
   logic signed [XW-1:0] tx_s, tx_m, ww_s;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [rmf_pkg::PIX_W-1:0] wr_pix, rd_pix;

   always_comb begin
      hh   = $signed(YW'(lat_h_ff));
      ww_s = $signed(XW'(lat_w_ff));
      ty_s = $signed(YW'(gy_ff)) + $signed(YW'(dy_ff)) - $signed(YW'(lat_m_ff));
      tx_s = $signed(XW'(gx_ff)) + $signed(XW'(dx_ff)) - $signed(XW'(lat_m_ff));
      if (ty_s < 0)        ty_m = -ty_s;
      else if (ty_s >= hh) ty_m = (hh - Y_ONE) + (hh - Y_ONE) - ty_s;
      else                 ty_m = ty_s;
      if (tx_s < 0)          tx_m = -tx_s;
      else if (tx_s >= ww_s) tx_m = (ww_s - X_ONE) + (ww_s - X_ONE) - tx_s;
      else                   tx_m = tx_s;
      rd_addr = {ty_m[RB-1:0], tx_m[CW-1:0]};
      wr_addr = {row_ff[RB-1:0], col_ff};
      wr_pix  = {req_data.in_red, req_data.in_green, req_data.in_blue};
   end

   rmf_ram #(
      .WIDTH (rmf_pkg::PIX_W),
      .DEPTH (1 << AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pix),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_pix)
   );

   // insertion chain, cleared when a gather starts
   rmf_pkg::cell_link_type links [NC+1];
   assign links[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      rmf_cell u_cell (
         .clock     (clock),
         .clear     (produce),
         .ins_en    (rd_pend_ff),
         .ins_value (rd_pix),
         .prev      (links[i]),
         .link      (links[i+1])
      );
   end

   // result register
   logic [rmf_pkg::PIX_W-1:0] med;
   assign med = links[int'(mid_ff) + 1].value;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_blue   = med[7:0];
         rsp_data_in.out_green  = med[15:8];
         rsp_data_in.out_red    = med[23:16];
         rsp_data_in.frame_last = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/rmf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rmf_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// One slot of an insertion chain, three independent byte lanes.
// ----------------------------------------------------------------------------
module rmf_cell (
   input  logic                         clock,
   input  logic                         clear,
   input  logic                         ins_en,
   input  logic [rmf_pkg::PIX_W-1:0]    ins_value,
   input  rmf_pkg::cell_link_type       prev,
   output rmf_pkg::cell_link_type       link
);

   logic [rmf_pkg::PIX_W-1:0] value_ff, value_in;
   logic [rmf_pkg::LANES-1:0] valid_ff, valid_in;
   logic [rmf_pkg::LANES-1:0] lt;

   // compare the broadcast sample with the held one, empty slot counts as top
   always_comb begin
      for (int c = 0; c < rmf_pkg::LANES; c++) begin
         lt[c] = !valid_ff[c] ||
                 (ins_value[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W] <
                  value_ff[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W]);
      end
   end

   // clear the slot, take from the neighbor, take the new sample, or hold
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (ins_en) begin
         for (int c = 0; c < rmf_pkg::LANES; c++) begin
            if (lt[c]) begin
               if (prev.lt[c]) begin
                  value_in[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W] =
                     prev.value[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W];
                  valid_in[c] = prev.valid[c];
               end else begin
                  value_in[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W] =
                     ins_value[c*rmf_pkg::SAMPLE_W +: rmf_pkg::SAMPLE_W];
                  valid_in[c] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      valid_ff <= valid_in;
   end

   assign link.lt    = lt;
   assign link.valid = valid_ff;
   assign link.value = value_ff;

endmodule
